@@ rtl/cpml_pkg.sv @@
// Shared types, constants and binary32 arithmetic for the PML coefficient unit.
// Used by every module under rtl/; depends on nothing else.
package cpml_pkg;

  typedef logic [31:0] f32_t;

  typedef struct packed {
    f32_t re;
    f32_t im;
  } cpx_t;

  typedef struct packed {
    logic [1:0] kind;
    f32_t       coord_x;
    f32_t       coord_y;
    f32_t       coord_z;
  } in_req_t;

  typedef struct packed {
    f32_t det_re;
    f32_t det_im;
    f32_t diag0_re;
    f32_t diag0_im;
    f32_t diag1_re;
    f32_t diag1_im;
    f32_t diag2_re;
    f32_t diag2_im;
  } out_rsp_t;

  localparam int NUM_AXES    = 3;
  localparam int LANE_DEPTH  = 16;
  localparam int MERGE_DEPTH = 9;
  localparam int PIPE_DEPTH  = LANE_DEPTH + MERGE_DEPTH;
  localparam int RCP_STAGES  = 9;
  localparam int RCP_BITS    = 3;
  localparam int T_DELAY     = 13;

  localparam f32_t F32_ONE  = 32'h3F80_0000;
  localparam f32_t F32_ZERO = 32'h0000_0000;
  localparam f32_t F32_QNAN = 32'h7FC0_0000;

  localparam logic [1:0] KIND_DET = 2'd0;
  localparam logic [1:0] KIND_DIV = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;

  localparam logic [2:0] CFG_AXES    = 3'd0;
  localparam logic [2:0] CFG_X_EDGES = 3'd1;
  localparam logic [2:0] CFG_Y_EDGES = 3'd2;
  localparam logic [2:0] CFG_Z_EDGES = 3'd3;
  localparam logic [2:0] CFG_X_GAINS = 3'd4;
  localparam logic [2:0] CFG_Y_GAINS = 3'd5;
  localparam logic [2:0] CFG_Z_GAINS = 3'd6;

  localparam logic [1:0] AXES_TWO = 2'd2;

  function automatic logic is_nan(f32_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(f32_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(f32_t a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic f32_t canon(f32_t a);
    return is_nan(a) ? F32_QNAN : a;
  endfunction

  function automatic f32_t fneg(f32_t a);
    return {~a[31], a[30:0]};
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // pn is nonzero with its top bit at 47; value is pn[47:24] * 2^(e-150)
  function automatic f32_t round_pack(logic s, logic signed [10:0] e, logic [47:0] pn);
    logic [47:0] ps;
    logic        st_x;
    logic [10:0] sh;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] mag;
    if (e >= 11'sd255) return {s, 8'hFF, 23'd0};
    if (e >= 11'sd1) begin
      ps   = pn;
      st_x = 1'b0;
      ef   = e[7:0];
    end else begin
      sh = 11'(11'sd1 - e);
      if (sh >= 11'd48) begin
        ps   = 48'd0;
        st_x = |pn;
      end else begin
        ps   = pn >> sh[5:0];
        st_x = |(pn & ((48'd1 << sh[5:0]) - 48'd1));
      end
      ef = 8'd0;
    end
    m   = ps[47:24];
    g   = ps[23];
    st  = (|ps[22:0]) | st_x;
    inc = g & (st | m[0]);
    mag = {ef, 23'd0} + {8'd0, m[22:0]} + 31'(inc);
    return {s, mag};
  endfunction

  function automatic f32_t fp_mul(f32_t a, f32_t b);
    logic                s;
    logic [23:0]         ma;
    logic [23:0]         mb;
    logic [7:0]          ea;
    logic [7:0]          eb;
    logic [47:0]         p;
    logic [5:0]          lz;
    logic signed [10:0]  e;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F32_QNAN;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return F32_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p  = {24'd0, ma} * {24'd0, mb};
    lz = lzc48(p);
    e  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126 - $signed({5'd0, lz});
    return round_pack(s, e, p << lz);
  endfunction

  function automatic f32_t fp_add(f32_t a, f32_t b);
    f32_t               x;
    f32_t               y;
    logic [23:0]        mx;
    logic [23:0]        my;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [7:0]         d;
    logic [27:0]        xa;
    logic [27:0]        ya;
    logic [27:0]        yb;
    logic [27:0]        s;
    logic [47:0]        pf;
    logic [5:0]         lz;
    logic signed [10:0] e;
    if (is_nan(a) || is_nan(b)) return F32_QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : F32_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    mx = {|x[30:23], x[22:0]};
    my = {|y[30:23], y[22:0]};
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    xa = {1'b0, mx, 3'b000};
    ya = {1'b0, my, 3'b000};
    if (d >= 8'd28) begin
      yb = 28'(|my);
    end else begin
      yb    = ya >> d[4:0];
      yb[0] = yb[0] | (|(ya & ((28'd1 << d[4:0]) - 28'd1)));
    end
    s = (x[31] ^ y[31]) ? (xa - yb) : (xa + yb);
    if (s == 28'd0) return F32_ZERO;
    pf = {s, 20'd0};
    lz = lzc48(pf);
    e  = $signed({3'b000, ex}) + 11'sd1 - $signed({5'd0, lz});
    return round_pack(x[31], e, pf << lz);
  endfunction

  function automatic f32_t fp_sub(f32_t a, f32_t b);
    return fp_add(a, fneg(b));
  endfunction

  function automatic logic [31:0] order_key(f32_t a);
    return a[31] ? ~a : {1'b1, a[30:0]};
  endfunction

  // a <= b, false on any NaN
  function automatic logic fp_le(f32_t a, f32_t b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (is_zero(a) && is_zero(b)) return 1'b1;
    return order_key(a) <= order_key(b);
  endfunction

endpackage

@@ rtl/cpml_recip.sv @@
// Pipelined binary32 reciprocal for operands of at least one.
// Uses cpml_pkg; radix-2 restoring division, three quotient bits per stage.
module cpml_recip (
  input  logic            clk,
  input  logic            ce,
  input  cpml_pkg::f32_t  a_i,
  output cpml_pkg::f32_t  u_o
);

  logic [24:0] rem_r [cpml_pkg::RCP_STAGES+1];
  logic [26:0] q_r   [cpml_pkg::RCP_STAGES+1];
  logic [23:0] m_r   [cpml_pkg::RCP_STAGES+1];
  logic [7:0]  e_r   [cpml_pkg::RCP_STAGES+1];
  logic        nan_r [cpml_pkg::RCP_STAGES+1];
  logic        inf_r [cpml_pkg::RCP_STAGES+1];
  logic        one_r [cpml_pkg::RCP_STAGES+1];

  logic [24:0] rem_nxt [cpml_pkg::RCP_STAGES];
  logic [26:0] q_nxt   [cpml_pkg::RCP_STAGES];

  cpml_pkg::f32_t u_r;
  cpml_pkg::f32_t u_nxt;

  always_comb begin
    logic [24:0] rm;
    logic [26:0] qq;
    for (int i = 0; i < cpml_pkg::RCP_STAGES; i++) begin
      rm = rem_r[i];
      qq = q_r[i];
      for (int j = 0; j < cpml_pkg::RCP_BITS; j++) begin
        if (rm >= {1'b0, m_r[i]}) begin
          rm = rm - {1'b0, m_r[i]};
          qq = {qq[25:0], 1'b1};
        end else begin
          qq = {qq[25:0], 1'b0};
        end
        rm = {rm[23:0], 1'b0};
      end
      rem_nxt[i] = rm;
      q_nxt[i]   = qq;
    end
  end

  always_comb begin
    logic signed [9:0] e;
    logic [1:0]        sh;
    logic [26:0]       qs;
    logic              lost;
    logic [23:0]       kept;
    logic              g;
    logic              st;
    logic              inc;
    logic [7:0]        ef;
    logic [30:0]       mag;
    e  = 10'sd253 - $signed({2'b00, e_r[cpml_pkg::RCP_STAGES]});
    sh = (e >= 10'sd1) ? 2'd0 : 2'(10'sd1 - e);
    qs = q_r[cpml_pkg::RCP_STAGES] >> sh;
    unique case (sh)
      2'd2:    lost = |q_r[cpml_pkg::RCP_STAGES][1:0];
      2'd1:    lost = q_r[cpml_pkg::RCP_STAGES][0];
      default: lost = 1'b0;
    endcase
    kept = qs[26:3];
    g    = qs[2];
    st   = (|qs[1:0]) | lost | (rem_r[cpml_pkg::RCP_STAGES] != 25'd0);
    inc  = g & (st | kept[0]);
    ef   = (e >= 10'sd1) ? e[7:0] : 8'd0;
    mag  = {ef, 23'd0} + {8'd0, kept[22:0]} + 31'(inc);
    if (nan_r[cpml_pkg::RCP_STAGES]) begin
      u_nxt = cpml_pkg::F32_QNAN;
    end else if (inf_r[cpml_pkg::RCP_STAGES]) begin
      u_nxt = cpml_pkg::F32_ZERO;
    end else if (one_r[cpml_pkg::RCP_STAGES]) begin
      if (e_r[cpml_pkg::RCP_STAGES] == 8'd254) u_nxt = 32'h0040_0000;
      else u_nxt = {1'b0, 8'(8'd254 - e_r[cpml_pkg::RCP_STAGES]), 23'd0};
    end else begin
      u_nxt = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= 25'h100_0000;
      q_r[0]   <= 27'd0;
      m_r[0]   <= {1'b1, a_i[22:0]};
      e_r[0]   <= a_i[30:23];
      nan_r[0] <= cpml_pkg::is_nan(a_i);
      inf_r[0] <= cpml_pkg::is_inf(a_i);
      one_r[0] <= a_i[22:0] == 23'd0;
      for (int i = 1; i <= cpml_pkg::RCP_STAGES; i++) begin
        rem_r[i] <= rem_nxt[i-1];
        q_r[i]   <= q_nxt[i-1];
        m_r[i]   <= m_r[i-1];
        e_r[i]   <= e_r[i-1];
        nan_r[i] <= nan_r[i-1];
        inf_r[i] <= inf_r[i-1];
        one_r[i] <= one_r[i-1];
      end
      u_r <= u_nxt;
    end
  end

  assign u_o = u_r;

endmodule

@@ rtl/cpml_cmul.sv @@
// Two-stage binary32 complex multiplier: four products, then a sum and a difference.
// Uses cpml_pkg.
module cpml_cmul (
  input  logic           clk,
  input  logic           ce,
  input  cpml_pkg::cpx_t a_i,
  input  cpml_pkg::cpx_t b_i,
  output cpml_pkg::cpx_t p_o
);

  cpml_pkg::f32_t p1_r;
  cpml_pkg::f32_t p2_r;
  cpml_pkg::f32_t p3_r;
  cpml_pkg::f32_t p4_r;
  cpml_pkg::cpx_t p_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_r    <= cpml_pkg::fp_mul(a_i.re, b_i.re);
      p2_r    <= cpml_pkg::fp_mul(a_i.im, b_i.im);
      p3_r    <= cpml_pkg::fp_mul(a_i.re, b_i.im);
      p4_r    <= cpml_pkg::fp_mul(a_i.im, b_i.re);
      p_r.re  <= cpml_pkg::fp_sub(p1_r, p2_r);
      p_r.im  <= cpml_pkg::fp_add(p3_r, p4_r);
    end
  end

  assign p_o = p_r;

endmodule

@@ rtl/cpml_lane.sv @@
// One axis lane: edge test, stretch t, and 1/(1+t*t) with t*u.
// Uses cpml_pkg and cpml_recip.
module cpml_lane (
  input  logic           clk,
  input  logic           ce,
  input  cpml_pkg::f32_t x_i,
  input  logic [63:0]    edges_i,
  input  logic [63:0]    gains_i,
  output cpml_pkg::f32_t t_o,
  output cpml_pkg::f32_t u_o,
  output cpml_pkg::f32_t tu_o
);

  cpml_pkg::f32_t d_r;
  cpml_pkg::f32_t g_r;
  logic           act_r;
  cpml_pkg::f32_t t_r;
  cpml_pkg::f32_t tt_r;
  cpml_pkg::f32_t a_r;
  cpml_pkg::f32_t t_d_r [cpml_pkg::T_DELAY];
  cpml_pkg::f32_t t_out_r;
  cpml_pkg::f32_t u_out_r;
  cpml_pkg::f32_t tu_r;
  cpml_pkg::f32_t u;
  logic           le_lo;
  logic           ge_hi;

  assign le_lo = cpml_pkg::fp_le(x_i, edges_i[31:0]);
  assign ge_hi = cpml_pkg::fp_le(edges_i[63:32], x_i);

  cpml_recip u_recip (
    .clk (clk),
    .ce  (ce),
    .a_i (a_r),
    .u_o (u)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      d_r   <= le_lo ? cpml_pkg::fp_sub(x_i, edges_i[31:0])
                     : cpml_pkg::fp_sub(x_i, edges_i[63:32]);
      g_r   <= le_lo ? gains_i[31:0] : gains_i[63:32];
      act_r <= le_lo | ge_hi;
      t_r   <= act_r ? cpml_pkg::fp_mul(g_r, {1'b0, d_r[30:0]}) : cpml_pkg::F32_ZERO;
      tt_r  <= cpml_pkg::fp_mul(t_r, t_r);
      a_r   <= cpml_pkg::fp_add(cpml_pkg::F32_ONE, tt_r);
      t_d_r[0] <= t_r;
      for (int i = 1; i < cpml_pkg::T_DELAY; i++) t_d_r[i] <= t_d_r[i-1];
      t_out_r <= t_d_r[cpml_pkg::T_DELAY-1];
      u_out_r <= u;
      tu_r    <= cpml_pkg::fp_mul(t_d_r[cpml_pkg::T_DELAY-1], u);
    end
  end

  assign t_o  = t_out_r;
  assign u_o  = u_out_r;
  assign tu_o = tu_r;

endmodule

@@ rtl/cpml_merge.sv @@
// Merge stage: det and inverse products, diagonal entries by kind, output register.
// Uses cpml_pkg and cpml_cmul.
module cpml_merge (
  input  logic               clk,
  input  logic               ce,
  input  cpml_pkg::f32_t     t_i  [cpml_pkg::NUM_AXES],
  input  cpml_pkg::f32_t     u_i  [cpml_pkg::NUM_AXES],
  input  cpml_pkg::f32_t     tu_i [cpml_pkg::NUM_AXES],
  input  logic [1:0]         kind_i,
  input  logic               two_axes_i,
  output cpml_pkg::out_rsp_t rsp_o
);

  cpml_pkg::cpx_t s   [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t r   [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t sq  [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t p   [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t w   [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t dg  [cpml_pkg::NUM_AXES];
  cpml_pkg::cpx_t r_sr_r  [cpml_pkg::NUM_AXES][6];
  cpml_pkg::cpx_t sq_sr_r [cpml_pkg::NUM_AXES][2];
  cpml_pkg::cpx_t w_sr_r  [cpml_pkg::NUM_AXES][2];
  cpml_pkg::cpx_t s2_sr_r [2];
  cpml_pkg::cpx_t det01_sr_r [2];
  cpml_pkg::cpx_t inv01_sr_r [2];
  cpml_pkg::cpx_t det_sr_r [4];
  cpml_pkg::cpx_t inv_sr_r [4];
  logic [1:0]     kind_sr_r [8];
  cpml_pkg::cpx_t det01;
  cpml_pkg::cpx_t inv01;
  cpml_pkg::cpx_t det3;
  cpml_pkg::cpx_t inv3;
  cpml_pkg::cpx_t det;
  cpml_pkg::cpx_t inv;
  cpml_pkg::out_rsp_t rsp_r;
  cpml_pkg::out_rsp_t rsp_nxt;

  always_comb begin
    for (int k = 0; k < cpml_pkg::NUM_AXES; k++) begin
      s[k].re = cpml_pkg::F32_ONE;
      s[k].im = t_i[k];
      r[k].re = u_i[k];
      r[k].im = cpml_pkg::fneg(tu_i[k]);
    end
  end

  cpml_cmul u_det01 (.clk(clk), .ce(ce), .a_i(s[0]), .b_i(s[1]), .p_o(det01));
  cpml_cmul u_inv01 (.clk(clk), .ce(ce), .a_i(r[0]), .b_i(r[1]), .p_o(inv01));
  cpml_cmul u_det3  (.clk(clk), .ce(ce), .a_i(det01), .b_i(s2_sr_r[1]), .p_o(det3));
  cpml_cmul u_inv3  (.clk(clk), .ce(ce), .a_i(inv01), .b_i(r_sr_r[2][1]), .p_o(inv3));

  assign det = two_axes_i ? det01_sr_r[1] : det3;
  assign inv = two_axes_i ? inv01_sr_r[1] : inv3;

  for (genvar k = 0; k < cpml_pkg::NUM_AXES; k++) begin : g_axis
    cpml_cmul u_sq (.clk(clk), .ce(ce), .a_i(s[k]), .b_i(s[k]), .p_o(sq[k]));
    cpml_cmul u_p  (.clk(clk), .ce(ce), .a_i(det), .b_i(r_sr_r[k][3]), .p_o(p[k]));
    cpml_cmul u_w  (.clk(clk), .ce(ce), .a_i(sq_sr_r[k][1]), .b_i(inv), .p_o(w[k]));
    cpml_cmul u_dg (.clk(clk), .ce(ce), .a_i(p[k]), .b_i(r_sr_r[k][5]), .p_o(dg[k]));
  end

  always_comb begin
    cpml_pkg::cpx_t dsel [cpml_pkg::NUM_AXES];
    for (int k = 0; k < cpml_pkg::NUM_AXES; k++) dsel[k] = '0;
    unique case (kind_sr_r[7])
      cpml_pkg::KIND_DIV: begin
        dsel[0] = dg[0];
        dsel[1] = dg[1];
        if (!two_axes_i) dsel[2] = dg[2];
      end
      cpml_pkg::KIND_MUL: begin
        if (two_axes_i) begin
          dsel[0] = inv_sr_r[3];
          dsel[1] = inv_sr_r[3];
        end else begin
          dsel[0] = w_sr_r[0][1];
          dsel[1] = w_sr_r[1][1];
          dsel[2] = w_sr_r[2][1];
        end
      end
      default: ;
    endcase
    rsp_nxt.det_re   = cpml_pkg::canon(det_sr_r[3].re);
    rsp_nxt.det_im   = cpml_pkg::canon(det_sr_r[3].im);
    rsp_nxt.diag0_re = cpml_pkg::canon(dsel[0].re);
    rsp_nxt.diag0_im = cpml_pkg::canon(dsel[0].im);
    rsp_nxt.diag1_re = cpml_pkg::canon(dsel[1].re);
    rsp_nxt.diag1_im = cpml_pkg::canon(dsel[1].im);
    rsp_nxt.diag2_re = cpml_pkg::canon(dsel[2].re);
    rsp_nxt.diag2_im = cpml_pkg::canon(dsel[2].im);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < cpml_pkg::NUM_AXES; k++) begin
        r_sr_r[k][0] <= r[k];
        for (int i = 1; i < 6; i++) r_sr_r[k][i] <= r_sr_r[k][i-1];
        sq_sr_r[k][0] <= sq[k];
        sq_sr_r[k][1] <= sq_sr_r[k][0];
        w_sr_r[k][0]  <= w[k];
        w_sr_r[k][1]  <= w_sr_r[k][0];
      end
      s2_sr_r[0]    <= s[2];
      s2_sr_r[1]    <= s2_sr_r[0];
      det01_sr_r[0] <= det01;
      det01_sr_r[1] <= det01_sr_r[0];
      inv01_sr_r[0] <= inv01;
      inv01_sr_r[1] <= inv01_sr_r[0];
      det_sr_r[0]   <= det;
      inv_sr_r[0]   <= inv;
      for (int i = 1; i < 4; i++) begin
        det_sr_r[i] <= det_sr_r[i-1];
        inv_sr_r[i] <= inv_sr_r[i-1];
      end
      kind_sr_r[0] <= kind_i;
      for (int i = 1; i < 8; i++) kind_sr_r[i] <= kind_sr_r[i-1];
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp_o = rsp_r;

endmodule

@@ rtl/cartesian_pml_coefficient.sv @@
// Cartesian PML coefficient unit: complex stretch factors, det and diagonal.
// Takes one request per cycle while the pipeline is not held.
// The whole pipeline advances together; it holds only while a result waits stalled.
// Reset (synchronous, rst_n low) empties the pipeline and restores the registers.
// Uses cpml_pkg, cpml_lane, cpml_merge.
module cartesian_pml_coefficient (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpml_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cpml_pkg::out_rsp_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [1:0]     axes_r;
  logic [63:0]    edges_r [cpml_pkg::NUM_AXES];
  logic [63:0]    gains_r [cpml_pkg::NUM_AXES];
  logic           vld_r   [cpml_pkg::PIPE_DEPTH];
  logic [1:0]     kind_r  [cpml_pkg::LANE_DEPTH];
  logic           ce;
  cpml_pkg::f32_t coord [cpml_pkg::NUM_AXES];
  cpml_pkg::f32_t t     [cpml_pkg::NUM_AXES];
  cpml_pkg::f32_t u     [cpml_pkg::NUM_AXES];
  cpml_pkg::f32_t tu    [cpml_pkg::NUM_AXES];

  assign ce        = !(out_valid && out_stall);
  assign in_stall  = !ce;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[cpml_pkg::PIPE_DEPTH-1];

  assign coord[0] = in_data.coord_x;
  assign coord[1] = in_data.coord_y;
  assign coord[2] = in_data.coord_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axes_r <= 2'd3;
      for (int k = 0; k < cpml_pkg::NUM_AXES; k++) begin
        edges_r[k] <= 64'd0;
        gains_r[k] <= 64'd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpml_pkg::CFG_AXES:    axes_r     <= cfg_data[1:0];
        cpml_pkg::CFG_X_EDGES: edges_r[0] <= cfg_data;
        cpml_pkg::CFG_Y_EDGES: edges_r[1] <= cfg_data;
        cpml_pkg::CFG_Z_EDGES: edges_r[2] <= cfg_data;
        cpml_pkg::CFG_X_GAINS: gains_r[0] <= cfg_data;
        cpml_pkg::CFG_Y_GAINS: gains_r[1] <= cfg_data;
        cpml_pkg::CFG_Z_GAINS: gains_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cpml_pkg::PIPE_DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < cpml_pkg::PIPE_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      kind_r[0] <= in_data.kind;
      for (int i = 1; i < cpml_pkg::LANE_DEPTH; i++) kind_r[i] <= kind_r[i-1];
    end
  end

  for (genvar k = 0; k < cpml_pkg::NUM_AXES; k++) begin : g_lane
    cpml_lane u_lane (
      .clk     (clk),
      .ce      (ce),
      .x_i     (coord[k]),
      .edges_i (edges_r[k]),
      .gains_i (gains_r[k]),
      .t_o     (t[k]),
      .u_o     (u[k]),
      .tu_o    (tu[k])
    );
  end

  cpml_merge u_merge (
    .clk        (clk),
    .ce         (ce),
    .t_i        (t),
    .u_i        (u),
    .tu_i       (tu),
    .kind_i     (kind_r[cpml_pkg::LANE_DEPTH-1]),
    .two_axes_i (axes_r == cpml_pkg::AXES_TWO),
    .rsp_o      (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request not in first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(vld_r[cpml_pkg::PIPE_DEPTH-2]))
    else $error("pipeline moved while result stalled");

  a_det_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.det_re[30:23] != 8'hFF) || (out_data.det_re[22:0] == 23'd0)
                  || (out_data.det_re == cpml_pkg::F32_QNAN))
    else $error("non-canonical NaN in det_re");

  a_diag_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.diag0_im[30:23] != 8'hFF) || (out_data.diag0_im[22:0] == 23'd0)
                  || (out_data.diag0_im == cpml_pkg::F32_QNAN))
    else $error("non-canonical NaN in diag0_im");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for cartesian_pml_coefficient: drives requests and register writes,
// predicts every result with its own binary32 arithmetic and compares field by field.
// Depends on cpml_pkg and the top level of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [31:0] PINF = 32'h7F80_0000;

  class pml_scoreboard;
    logic [1:0]  axes;
    logic [63:0] edges [3];
    logic [63:0] gains [3];
    cpml_pkg::out_rsp_t expected_rsp [$];
    int          errors;

    function new();
      axes = 2'd3;
      for (int k = 0; k < 3; k++) begin
        edges[k] = '0;
        gains[k] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      unique case (idx)
        cpml_pkg::CFG_AXES: axes = d[1:0];
        cpml_pkg::CFG_X_EDGES, cpml_pkg::CFG_Y_EDGES, cpml_pkg::CFG_Z_EDGES:
          edges[idx - cpml_pkg::CFG_X_EDGES] = d;
        cpml_pkg::CFG_X_GAINS, cpml_pkg::CFG_Y_GAINS, cpml_pkg::CFG_Z_GAINS:
          gains[idx - cpml_pkg::CFG_X_GAINS] = d;
        default: ;
      endcase
    endfunction

    function bit nan32(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    function bit inf32(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 0;
    endfunction

    function bit zero32(logic [31:0] a);
      return a[30:0] == 0;
    endfunction

    function void split(logic [31:0] a, output logic [127:0] m, output int e);
      m = {104'd0, a[30:23] != 0, a[22:0]};
      e = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    // value is m * 2^e, sticky marks nonzero bits lost below m
    function logic [31:0] round_rne(bit s, logic [127:0] m, int e, bit sticky);
      int p, sh, q;
      logic [127:0] k;
      bit g, r;
      if (m == 0) return {s, 31'd0};
      p = 127;
      while (!m[p]) p--;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh > 128) begin
        k = 0;
        g = 0;
        r = 1;
      end else if (sh > 0) begin
        k = m >> sh;
        g = m[sh - 1];
        r = |(m & ((128'd1 << (sh - 1)) - 1));
      end else begin
        k = m << (-sh);
        g = 0;
        r = 0;
      end
      r = r | sticky;
      q = e + sh;
      if (g && (r || k[0])) k = k + 1;
      if (k[24]) begin
        k = k >> 1;
        q++;
      end
      if (!k[23]) return {s, 8'd0, k[22:0]};
      if (q + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(q + 150), k[22:0]};
    endfunction

    function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (nan32(a) || nan32(b)) return QNAN;
      if ((inf32(a) && zero32(b)) || (zero32(a) && inf32(b))) return QNAN;
      if (inf32(a) || inf32(b)) return {s, PINF[30:0]};
      if (zero32(a) || zero32(b)) return {s, 31'd0};
      split(a, ma, ea);
      split(b, mb, eb);
      return round_rne(s, ma * mb, ea + eb, 0);
    endfunction

    function logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma, mb, ml, ms, tm;
      int ea, eb, e, d, te;
      bit sa, sb, ts;
      if (nan32(a) || nan32(b)) return QNAN;
      if (inf32(a) && inf32(b)) return (a[31] == b[31]) ? a : QNAN;
      if (inf32(a)) return a;
      if (inf32(b)) return b;
      if (zero32(a) && zero32(b)) return {a[31] & b[31], 31'd0};
      if (zero32(a)) return b;
      if (zero32(b)) return a;
      split(a, ma, ea);
      split(b, mb, eb);
      sa = a[31];
      sb = b[31];
      if (ea < eb) begin
        tm = ma; ma = mb; mb = tm;
        te = ea; ea = eb; eb = te;
        ts = sa; sa = sb; sb = ts;
      end
      d = ea - eb;
      if (d > 50) begin
        ml = ma << 50;
        ms = 1;
        e  = ea - 50;
      end else begin
        ml = ma << d;
        ms = mb;
        e  = eb;
      end
      if (sa == sb) return round_rne(sa, ml + ms, e, 0);
      if (ml > ms) return round_rne(sa, ml - ms, e, 0);
      if (ms > ml) return round_rne(sb, ms - ml, e, 0);
      return 32'd0;
    endfunction

    function logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
      logic [127:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (nan32(a) || nan32(b)) return QNAN;
      if ((inf32(a) && inf32(b)) || (zero32(a) && zero32(b))) return QNAN;
      if (inf32(a) || zero32(b)) return {s, PINF[30:0]};
      if (zero32(a) || inf32(b)) return {s, 31'd0};
      split(a, ma, ea);
      split(b, mb, eb);
      return round_rne(s, (ma << 100) / mb, ea - eb - 100, ((ma << 100) % mb) != 0);
    endfunction

    function logic [31:0] sort_key(logic [31:0] a);
      return a[31] ? ~a : {1'b1, a[30:0]};
    endfunction

    function bit f_le(logic [31:0] a, logic [31:0] b);
      if (nan32(a) || nan32(b)) return 0;
      if (zero32(a) && zero32(b)) return 1;
      return sort_key(a) <= sort_key(b);
    endfunction

    function cpml_pkg::cpx_t c_mul(cpml_pkg::cpx_t a, cpml_pkg::cpx_t b);
      cpml_pkg::cpx_t r;
      r.re = f_add(f_mul(a.re, b.re), fneg_own(f_mul(a.im, b.im)));
      r.im = f_add(f_mul(a.re, b.im), f_mul(a.im, b.re));
      return r;
    endfunction

    function logic [31:0] fneg_own(logic [31:0] a);
      return {~a[31], a[30:0]};
    endfunction

    function logic [31:0] nan_fix(logic [31:0] a);
      return nan32(a) ? QNAN : a;
    endfunction

    function void note_request(cpml_pkg::in_req_t req);
      cpml_pkg::cpx_t s [3], r [3], dg [3], det, inv;
      logic [31:0] x, lo, hi, t, u;
      int n;
      cpml_pkg::out_rsp_t rsp;
      for (int k = 0; k < 3; k++) begin
        x  = (k == 0) ? req.coord_x : (k == 1) ? req.coord_y : req.coord_z;
        lo = edges[k][31:0];
        hi = edges[k][63:32];
        t  = 32'd0;
        if (f_le(hi, x))
          t = f_mul(gains[k][63:32], f_add(x, fneg_own(hi)) & 32'h7FFF_FFFF);
        if (f_le(x, lo))
          t = f_mul(gains[k][31:0], f_add(x, fneg_own(lo)) & 32'h7FFF_FFFF);
        u = f_div(cpml_pkg::F32_ONE, f_add(cpml_pkg::F32_ONE, f_mul(t, t)));
        s[k]  = '{cpml_pkg::F32_ONE, t};
        r[k]  = '{u, fneg_own(f_mul(t, u))};
        dg[k] = '{32'd0, 32'd0};
      end
      n   = (axes == cpml_pkg::AXES_TWO) ? 2 : 3;
      det = s[0];
      inv = r[0];
      for (int k = 1; k < n; k++) begin
        det = c_mul(det, s[k]);
        inv = c_mul(inv, r[k]);
      end
      if (req.kind == cpml_pkg::KIND_DIV) begin
        for (int k = 0; k < n; k++) dg[k] = c_mul(c_mul(det, r[k]), r[k]);
      end else if (req.kind == cpml_pkg::KIND_MUL) begin
        if (n == 2) begin
          dg[0] = inv;
          dg[1] = inv;
        end else begin
          for (int k = 0; k < n; k++) dg[k] = c_mul(c_mul(s[k], s[k]), inv);
        end
      end
      rsp.det_re   = nan_fix(det.re);
      rsp.det_im   = nan_fix(det.im);
      rsp.diag0_re = nan_fix(dg[0].re);
      rsp.diag0_im = nan_fix(dg[0].im);
      rsp.diag1_re = nan_fix(dg[1].re);
      rsp.diag1_im = nan_fix(dg[1].im);
      rsp.diag2_re = nan_fix(dg[2].re);
      rsp.diag2_im = nan_fix(dg[2].im);
      expected_rsp.push_back(rsp);
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(cpml_pkg::out_rsp_t got);
      cpml_pkg::out_rsp_t want;
      logic [255:0] g, w;
      string names [8] = '{"det_re", "det_im", "diag0_re", "diag0_im",
                           "diag1_re", "diag1_im", "diag2_re", "diag2_im"};
      if (expected_rsp.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = expected_rsp.pop_front();
      g = got;
      w = want;
      for (int i = 0; i < 8; i++) begin
        if (g[255 - 32 * i -: 32] !== w[255 - 32 * i -: 32])
          report($sformatf("%s got %08h expected %08h", names[i],
                           g[255 - 32 * i -: 32], w[255 - 32 * i -: 32]));
      end
    endtask

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cpml_pkg::in_req_t  in_data;
  logic               out_valid;
  logic               out_stall;
  cpml_pkg::out_rsp_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  pml_scoreboard sb;
  bit squeeze;
  int idle_cycles;

  cartesian_pml_coefficient i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    squeeze   = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("cartesian_pml_coefficient test failed");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end else
      idle_cycles <= 0;
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int cyc, hold;
    cyc  = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (squeeze) begin
        squeeze = 1'b0;
        hold = 300;
        out_stall <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        unique case ((cyc / 97) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 16) < 5);
        endcase
      end
    end
  end

  task automatic send_request(cpml_pkg::in_req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] specials [8] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001,
                                  32'h8000_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000};
    unique case ($urandom_range(0, 9))
      0: return $urandom;
      1: return specials[$urandom_range(0, 7)];
      default: return {1'($urandom), 8'($urandom_range(118, 129)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_mag();
    return {1'b0, 8'($urandom_range(120, 129)), 23'($urandom)};
  endfunction

  function automatic cpml_pkg::in_req_t make_req(logic [1:0] k, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z);
    cpml_pkg::in_req_t r;
    r.kind    = k;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    return r;
  endfunction

  initial begin
    cpml_pkg::in_req_t directed [$];
    int burst, gap;
    logic [63:0] ed, gn;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: zero gains, so infinite distance gives NaN stretch
    send_request(make_req(cpml_pkg::KIND_MUL, 32'h7F80_0000, 32'h3F80_0000, 32'hBF80_0000));
    send_request(make_req(cpml_pkg::KIND_DIV, 32'h0000_0000, 32'h8000_0000, 32'h4040_0000));
    drain();

    write_cfg(cpml_pkg::CFG_AXES, 64'd3);
    write_cfg(cpml_pkg::CFG_X_EDGES, {32'h3F80_0000, 32'hBF80_0000});
    write_cfg(cpml_pkg::CFG_Y_EDGES, {32'h3F80_0000, 32'hBF80_0000});
    write_cfg(cpml_pkg::CFG_Z_EDGES, {32'h3F80_0000, 32'hBF80_0000});
    write_cfg(cpml_pkg::CFG_X_GAINS, {32'h4000_0000, 32'h3F00_0000});
    write_cfg(cpml_pkg::CFG_Y_GAINS, {32'h3F00_0000, 32'h4000_0000});
    write_cfg(cpml_pkg::CFG_Z_GAINS, {32'h4000_0000, 32'h4000_0000});
    write_cfg(CFG_UNUSED, '1);

    directed.push_back(make_req(cpml_pkg::KIND_DET, 32'h0000_0000, 32'h0000_0000,
                                32'h0000_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DIV, 32'h0000_0000, 32'h3F00_0000,
                                32'hBF00_0000));
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h0000_0000, 32'h3F00_0000,
                                32'hBF00_0000));
    directed.push_back(make_req(2'd3, 32'h4040_0000, 32'hC040_0000, 32'h4040_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DET, 32'h4040_0000, 32'hC040_0000,
                                32'h4040_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DIV, 32'h4040_0000, 32'hC040_0000,
                                32'h4040_0000));
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h4040_0000, 32'hC040_0000,
                                32'h4040_0000));
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h3F80_0000, 32'hBF80_0000,
                                32'h3F80_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DIV, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                32'h7F80_0001));
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h7F80_0000, 32'hFF80_0000,
                                32'h0000_0001));
    directed.push_back(make_req(cpml_pkg::KIND_DIV, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                                32'h8000_0001));
    directed.push_back(make_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_req(cpml_pkg::KIND_DET, 32'h5F00_0000, 32'hDF00_0000,
                                32'h3F80_0001));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    write_cfg(cpml_pkg::CFG_AXES, 64'd2);
    directed.delete();
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h4040_0000, 32'hC040_0000,
                                32'h7F80_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DIV, 32'h4040_0000, 32'h0000_0000,
                                32'h4040_0000));
    directed.push_back(make_req(cpml_pkg::KIND_DET, 32'hC040_0000, 32'h4040_0000,
                                32'hFFFF_FFFF));
    directed.push_back(make_req(2'd3, 32'hC040_0000, 32'h4040_0000, 32'h0000_0000));
    // both edge tests hold when lower edge sits above upper; the lower edge wins
    directed.push_back(make_req(cpml_pkg::KIND_MUL, 32'h0000_0000, 32'h0000_0000,
                                32'h0000_0000));
    foreach (directed[i]) begin
      if (i == 4) begin
        drain();
        write_cfg(cpml_pkg::CFG_X_EDGES, {32'hBF80_0000, 32'h3F80_0000});
      end
      send_request(directed[i]);
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      write_cfg(cpml_pkg::CFG_AXES, 64'(p % 4));
      for (int k = 0; k < 3; k++) begin
        case (p)
          5: ed = {32'hBF80_0000, 32'h3F80_0000};
          6: ed = '1;
          7: ed = '0;
          default: ed = {rand_mag(), rand_mag() | 32'h8000_0000};
        endcase
        case (p)
          6: gn = '1;
          7: gn = {32'h7F7F_FFFF, 32'h7F7F_FFFF};
          3: gn = {$urandom, $urandom};
          default: gn = {rand_mag(), rand_mag()};
        endcase
        write_cfg(cpml_pkg::CFG_X_EDGES + 3'(k), ed);
        write_cfg(cpml_pkg::CFG_X_GAINS + 3'(k), gn);
      end
      if (p == 2) squeeze = 1'b1;
      burst = 0;
      for (int i = 0; i < 200; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = (p % 3 == 1) ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst--;
        send_request(make_req(2'($urandom), rand_float(), rand_float(), rand_float()));
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("cartesian_pml_coefficient test passed");
    else
      $display("cartesian_pml_coefficient test failed");
    $finish;
  end
endmodule
